FILE: sv/signed_decimal_long_divider_defines.svh
// Assertion macros used by the checker file of the signed decimal long divider.
`ifndef SIGNED_DECIMAL_LONG_DIVIDER_DEFINES_SVH
`define SIGNED_DECIMAL_LONG_DIVIDER_DEFINES_SVH

// Concurrent assertion on an explicit clock, disabled while the reset is high.
`define SDLD_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define SDLD_ASSERT(lbl, prop, msg) `SDLD_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

FILE: sv/sdld_pkg.sv
// Shared types, constants and status codes of the signed decimal long divider.
package sdld_pkg;

   // Fixed field widths
   localparam int OPERAND_W   = 32;
   localparam int SCALE_W     = 6;
   localparam int DIGIT_CNT_W = 4;

   // Defaults for the top-level parameters
   localparam int FRACTION_DIGITS_DEF = 8;
   localparam int DATA_WIDTH_DEF      = 32;

   // Restoring divider step counts
   localparam int INT_STEPS    = OPERAND_W;
   localparam int DIGIT_STEPS  = 4;
   localparam int STEP_CNT_W   = $clog2(INT_STEPS);

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DIV0 = 2'd1,
      STATUS_OVF  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INT,
      ST_QCHK,
      ST_DTEST,
      ST_DSTEP,
      ST_DACC
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic                   start_ld;
      logic                   div_step;
      logic                   dig_ld;
      logic                   acc_ld;
      logic                   acc_add;
      logic                   fin;
      status_type             fin_status;
      logic [DIGIT_CNT_W-1:0] fin_digits;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div0;
      logic q_ovf;
      logic rem_zero;
      logic rem_big;
      logic acc_ovf;
   } sts_type;

endpackage

FILE: sv/sdld_ctrl.sv
// Sequencer of the signed decimal long divider: integer phase, digit phase, finish.
module sdld_ctrl #(
   parameter int FRACTION_DIGITS = sdld_pkg::FRACTION_DIGITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   input  sdld_pkg::sts_type sts,
   output sdld_pkg::cmd_type cmd
);

   localparam logic [sdld_pkg::STEP_CNT_W-1:0] INT_LAST =
      sdld_pkg::STEP_CNT_W'(sdld_pkg::INT_STEPS - 1);
   localparam logic [sdld_pkg::STEP_CNT_W-1:0] DIG_LAST =
      sdld_pkg::STEP_CNT_W'(sdld_pkg::DIGIT_STEPS - 1);
   localparam logic [sdld_pkg::DIGIT_CNT_W-1:0] DIG_MAX =
      sdld_pkg::DIGIT_CNT_W'(FRACTION_DIGITS);

   sdld_pkg::state_type                 state_ff, state_in;
   logic [sdld_pkg::STEP_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [sdld_pkg::DIGIT_CNT_W-1:0]    dig_ff, dig_in;
   logic                                valid_ff, valid_in;

   // State, counters and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdld_pkg::ST_IDLE;
         cnt_ff   <= '0;
         dig_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         dig_ff   <= dig_in;
         valid_ff <= valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      dig_in         = dig_ff;
      valid_in       = 1'b0;
      cmd            = '0;
      cmd.fin_digits = dig_ff;
      case (state_ff)
         sdld_pkg::ST_IDLE: begin
            if (start) begin
               cmd.start_ld = 1'b1;
               cnt_in       = '0;
               state_in     = sdld_pkg::ST_INT;
            end
         end
         sdld_pkg::ST_INT: begin
            if (sts.div0) begin
               cmd.fin        = 1'b1;
               cmd.fin_status = sdld_pkg::STATUS_DIV0;
               valid_in       = 1'b1;
               state_in       = sdld_pkg::ST_IDLE;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == INT_LAST) begin
                  state_in = sdld_pkg::ST_QCHK;
               end
            end
         end
         sdld_pkg::ST_QCHK: begin
            if (sts.q_ovf) begin
               cmd.fin        = 1'b1;
               cmd.fin_status = sdld_pkg::STATUS_OVF;
               valid_in       = 1'b1;
               state_in       = sdld_pkg::ST_IDLE;
            end else begin
               cmd.acc_ld = 1'b1;
               dig_in     = '0;
               state_in   = sdld_pkg::ST_DTEST;
            end
         end
         sdld_pkg::ST_DTEST: begin
            // stop on an exact remainder or when all digits are out
            if (sts.rem_zero || (dig_ff == DIG_MAX)) begin
               cmd.fin        = 1'b1;
               cmd.fin_status = sdld_pkg::STATUS_OK;
               valid_in       = 1'b1;
               state_in       = sdld_pkg::ST_IDLE;
            end else if (sts.rem_big) begin
               cmd.fin        = 1'b1;
               cmd.fin_status = sdld_pkg::STATUS_OVF;
               valid_in       = 1'b1;
               state_in       = sdld_pkg::ST_IDLE;
            end else begin
               cmd.dig_ld = 1'b1;
               cnt_in     = '0;
               state_in   = sdld_pkg::ST_DSTEP;
            end
         end
         sdld_pkg::ST_DSTEP: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIG_LAST) begin
               state_in = sdld_pkg::ST_DACC;
            end
         end
         sdld_pkg::ST_DACC: begin
            if (sts.acc_ovf) begin
               cmd.fin        = 1'b1;
               cmd.fin_status = sdld_pkg::STATUS_OVF;
               valid_in       = 1'b1;
               state_in       = sdld_pkg::ST_IDLE;
            end else begin
               cmd.acc_add = 1'b1;
               dig_in      = dig_ff + 1'b1;
               state_in    = sdld_pkg::ST_DTEST;
            end
         end
         default: begin
            state_in = sdld_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != sdld_pkg::ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

FILE: sv/sdld_datapath.sv
// Datapath of the signed decimal long divider: shared restoring divider, accumulator, result.
module sdld_datapath #(
   parameter int DATA_WIDTH = sdld_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic signed [sdld_pkg::OPERAND_W-1:0] req_dividend,
   input  logic signed [sdld_pkg::OPERAND_W-1:0] req_divisor,
   input  logic signed [sdld_pkg::SCALE_W-1:0]   req_scale_in,
   input  sdld_pkg::cmd_type                   cmd,
   output sdld_pkg::sts_type                   sts,
   output logic signed [sdld_pkg::OPERAND_W-1:0] rsp_scaled_result,
   output logic signed [sdld_pkg::SCALE_W-1:0]   rsp_decimal_exponent,
   output logic [1:0]                          rsp_status
);

   localparam int OW = sdld_pkg::OPERAND_W;
   localparam int SW = sdld_pkg::SCALE_W;
   // compare width: holds the magnitude limit, ten times the accumulator, and ten times a remainder
   localparam int CW = ((DATA_WIDTH > OW) ? DATA_WIDTH : OW) + 4;
   localparam int AW = DATA_WIDTH - 1;
   localparam logic [CW-1:0] LIM       = (CW'(1) << (DATA_WIDTH - 1)) - CW'(1);
   localparam logic [CW-1:0] LIM_DIV10 = LIM / 10;

   logic [OW-1:0]     a_bits, b_bits, a_mag, b_mag;
   logic [OW-1:0]     mb_ff, rem_ff, sh_ff;
   logic              neg_ff;
   logic [SW-1:0]     scale_ff;
   logic [AW-1:0]     acc_ff;
   logic [OW-1:0]     res_ff;
   logic [SW-1:0]     exp_ff;
   sdld_pkg::status_type status_ff;

   logic [OW:0]       trial, diff;
   logic              take;
   logic [OW+3:0]     times_ten;
   logic [3:0]        digit;
   logic [CW-1:0]     acc_x, sh_x, rem_x, digit_x, acc_nx, signed_x;

   // Operand magnitudes
   assign a_bits = req_dividend;
   assign b_bits = req_divisor;
   assign a_mag  = a_bits[OW-1] ? (OW'(0) - a_bits) : a_bits;
   assign b_mag  = b_bits[OW-1] ? (OW'(0) - b_bits) : b_bits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, sh_ff[OW-1]};
   assign diff  = trial - {1'b0, mb_ff};
   assign take  = ~diff[OW];

   // Remainder times ten for the next digit
   assign times_ten = {1'b0, rem_ff, 3'b000} + {3'b000, rem_ff, 1'b0};

   // Accumulator times ten plus the new digit
   assign digit   = sh_ff[3:0];
   assign acc_x   = {{(CW-AW){1'b0}}, acc_ff};
   assign sh_x    = {{(CW-OW){1'b0}}, sh_ff};
   assign rem_x   = {{(CW-OW){1'b0}}, rem_ff};
   assign digit_x = {{(CW-4){1'b0}}, digit};
   assign acc_nx  = {acc_x[CW-4:0], 3'b000} + {acc_x[CW-2:0], 1'b0} + digit_x;

   // Status toward the controller
   assign sts.div0     = (mb_ff == '0);
   assign sts.q_ovf    = (sh_x > LIM);
   assign sts.rem_zero = (rem_ff == '0);
   assign sts.rem_big  = (rem_x > LIM_DIV10);
   assign sts.acc_ovf  = (digit_x > LIM) || (acc_nx > LIM);

   // Signed result, low word of the two's complement value
   assign signed_x = neg_ff ? (CW'(0) - acc_x) : acc_x;

   // Operand capture and divider registers
   always_ff @(posedge clock) begin
      if (cmd.start_ld) begin
         mb_ff    <= b_mag;
         neg_ff   <= (a_mag != '0) && (a_bits[OW-1] != b_bits[OW-1]);
         scale_ff <= req_scale_in;
         rem_ff   <= '0;
         sh_ff    <= a_mag;
      end else if (cmd.dig_ld) begin
         rem_ff <= times_ten[OW+3:4];
         sh_ff  <= {times_ten[3:0], {(OW-4){1'b0}}};
      end else if (cmd.div_step) begin
         rem_ff <= take ? diff[OW-1:0] : trial[OW-1:0];
         sh_ff  <= {sh_ff[OW-2:0], take};
      end
   end

   // Accumulator: load the integer quotient, then append digits
   always_ff @(posedge clock) begin
      if (cmd.acc_ld) begin
         acc_ff <= sh_x[AW-1:0];
      end else if (cmd.acc_add) begin
         acc_ff <= acc_nx[AW-1:0];
      end
   end

   // Result word; errors give zero payload
   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         status_ff <= cmd.fin_status;
         if (cmd.fin_status == sdld_pkg::STATUS_OK) begin
            res_ff <= signed_x[OW-1:0];
            exp_ff <= scale_ff + {{(SW-sdld_pkg::DIGIT_CNT_W){1'b0}}, cmd.fin_digits};
         end else begin
            res_ff <= '0;
            exp_ff <= '0;
         end
      end
   end

   assign rsp_scaled_result    = res_ff;
   assign rsp_decimal_exponent = exp_ff;
   assign rsp_status           = status_ff;

endmodule

FILE: sv/signed_decimal_long_divider.sv
// Top level of the signed decimal long divider: controller and datapath.
//
//   channel   direction  handshake             fields
//   request   in         start & !busy         req_dividend, req_divisor, req_scale_in
//   response  out        rsp_valid (1 cycle)   rsp_scaled_result, rsp_decimal_exponent,
//                                              rsp_status
//
// One word at a time. A word with an exact integer quotient gives its result after the
// integer phase and the quotient check; each fraction digit adds one load, four restoring
// steps of the shared subtractor and one accumulate, up to FRACTION_DIGITS digits. A zero
// divisor answers from the first integer step. busy drops in the cycle the strobe shows, so
// the next word can be taken then. Synchronous reset returns to idle and clears the strobe;
// the receiver takes every strobe as it comes.
module signed_decimal_long_divider #(
   parameter int FRACTION_DIGITS = sdld_pkg::FRACTION_DIGITS_DEF,
   parameter int DATA_WIDTH      = sdld_pkg::DATA_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [sdld_pkg::OPERAND_W-1:0] req_dividend,
   input  logic signed [sdld_pkg::OPERAND_W-1:0] req_divisor,
   input  logic signed [sdld_pkg::SCALE_W-1:0]   req_scale_in,
   output logic                                  rsp_valid,
   output logic signed [sdld_pkg::OPERAND_W-1:0] rsp_scaled_result,
   output logic signed [sdld_pkg::SCALE_W-1:0]   rsp_decimal_exponent,
   output logic [1:0]                            rsp_status
);

   sdld_pkg::cmd_type cmd;
   sdld_pkg::sts_type sts;

   // Sequencer
   sdld_ctrl #(
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Divider, accumulator and result registers
   sdld_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock                (clock),
      .req_dividend         (req_dividend),
      .req_divisor          (req_divisor),
      .req_scale_in         (req_scale_in),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_scaled_result    (rsp_scaled_result),
      .rsp_decimal_exponent (rsp_decimal_exponent),
      .rsp_status           (rsp_status)
   );

endmodule

FILE: sv/sdld_checker.sv
// Port-level checker of the signed decimal long divider and its bind.
`include "signed_decimal_long_divider_defines.svh"

module sdld_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  rsp_valid,
   input logic signed [sdld_pkg::OPERAND_W-1:0] rsp_scaled_result,
   input logic signed [sdld_pkg::SCALE_W-1:0]   rsp_decimal_exponent,
   input logic [1:0]                            rsp_status
);

   // accepted word keeps the block busy
   `SDLD_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")

   // a strobe only shows once the block is idle again
   `SDLD_ASSERT(a_strobe_idle, rsp_valid |-> !busy, "result strobe while busy")

   // busy ends only with a result
   `SDLD_ASSERT(a_done_strobe, ($fell(busy) && !$past(reset)) |-> rsp_valid,
      "busy dropped without a result")

   // error results carry zero payload
   `SDLD_ASSERT(a_err_zero,
      (rsp_valid && (rsp_status != sdld_pkg::STATUS_OK)) |->
         ((rsp_scaled_result == '0) && (rsp_decimal_exponent == '0)),
      "error result with nonzero payload")

endmodule

bind signed_decimal_long_divider sdld_checker u_sdld_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_scaled_result    (rsp_scaled_result),
   .rsp_decimal_exponent (rsp_decimal_exponent),
   .rsp_status           (rsp_status)
);

FILE: dv/quotient_monitor.sv
// Watches the divider's request and response ports, predicts each quotient and compares it.
module quotient_monitor
   import sdld_pkg::*;
#(
   parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
   parameter int DATA_WIDTH      = DATA_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic signed [OPERAND_W-1:0] req_dividend,
   input  logic signed [OPERAND_W-1:0] req_divisor,
   input  logic signed [SCALE_W-1:0]   req_scale_in,
   input  logic                        rsp_valid,
   input  logic signed [OPERAND_W-1:0] rsp_scaled_result,
   input  logic signed [SCALE_W-1:0]   rsp_decimal_exponent,
   input  logic [1:0]                  rsp_status,
   output int                          errors,
   output int                          outstanding
);

   localparam int MAX_SHOWN = 10;

   typedef struct {
      logic [OPERAND_W-1:0] num;
      logic [OPERAND_W-1:0] den;
      logic [SCALE_W-1:0]   scale;
      logic [OPERAND_W-1:0] value;
      logic [SCALE_W-1:0]   exponent;
      status_type           status;
   } quotient_word;

   quotient_word quotients_due[$];
   int           mismatch_cnt;

   // Long division of magnitudes, then up to FRACTION_DIGITS decimal digits
   function automatic quotient_word divide_word(logic [OPERAND_W-1:0] num,
                                                logic [OPERAND_W-1:0] den,
                                                logic [SCALE_W-1:0] scale);
      logic [63:0]  mag_limit, mag_num, mag_den, quo, rem, acc, tens, digit;
      logic         neg_num, neg_den;
      int           places;
      quotient_word res;
      mag_limit    = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
      neg_num      = num[OPERAND_W-1];
      neg_den      = den[OPERAND_W-1];
      mag_num      = {32'd0, neg_num ? (~num + 32'd1) : num};
      mag_den      = {32'd0, neg_den ? (~den + 32'd1) : den};
      res.num      = num;
      res.den      = den;
      res.scale    = scale;
      res.value    = '0;
      res.exponent = '0;
      res.status   = STATUS_OK;
      places       = 0;
      if (mag_den == 64'd0) begin
         res.status = STATUS_DIV0;
         return res;
      end
      quo = mag_num / mag_den;
      rem = mag_num % mag_den;
      if (quo > mag_limit) begin
         res.status = STATUS_OVF;
         return res;
      end
      acc = quo;
      // Append one digit per step of remainder times ten; stop on a zero remainder
      for (int i = 0; i < FRACTION_DIGITS; i++) begin
         if (rem == 64'd0) break;
         if (rem > mag_limit / 64'd10) begin
            res.status = STATUS_OVF;
            return res;
         end
         tens  = rem * 64'd10;
         digit = tens / mag_den;
         rem   = tens % mag_den;
         if (digit > mag_limit || acc > (mag_limit - digit) / 64'd10) begin
            res.status = STATUS_OVF;
            return res;
         end
         acc    = acc * 64'd10 + digit;
         places = places + 1;
      end
      // Negate when exactly one operand is negative; a zero dividend stays positive
      res.value    = (mag_num != 64'd0 && neg_num != neg_den) ? (32'd0 - acc[31:0])
                                                              : acc[31:0];
      res.exponent = scale + SCALE_W'(places);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      quotient_word want;
      if (reset) begin
         quotients_due.delete();
         mismatch_cnt = 0;
      end else begin
         // Compare each strobed result with the oldest pending quotient
         if (rsp_valid) begin
            if (quotients_due.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= MAX_SHOWN)
                  $display("quotient: result %0d e%0d status %0d with no word pending",
                           rsp_scaled_result, rsp_decimal_exponent, rsp_status);
            end else begin
               want = quotients_due.pop_front();
               if (rsp_scaled_result !== want.value || rsp_decimal_exponent !== want.exponent
                   || rsp_status !== want.status) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= MAX_SHOWN)
                     $display("quotient: %0d/%0d s%0d: want %0d e%0d st%0d, got %0d e%0d st%0d",
                              $signed(want.num), $signed(want.den), $signed(want.scale),
                              $signed(want.value), $signed(want.exponent), want.status,
                              rsp_scaled_result, rsp_decimal_exponent, rsp_status);
               end
            end
         end
         // Predict each accepted word
         if (start && !busy)
            quotients_due.insert(quotients_due.size(),
                                 divide_word(req_dividend, req_divisor, req_scale_in));
      end
      errors      <= mismatch_cnt;
      outstanding <= quotients_due.size();
   end

endmodule

FILE: dv/tb_top.sv
// Top of the divider testbench: clock, reset, stimulus and verdict.
module tb_top;
   import sdld_pkg::*;

   localparam int RUN_LIMIT    = 1_000_000;
   localparam int RANDOM_WORDS = 1350;
   localparam int DRAIN_CYCLES = 120;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic signed [OPERAND_W-1:0] req_dividend;
   logic signed [OPERAND_W-1:0] req_divisor;
   logic signed [SCALE_W-1:0]   req_scale_in;
   logic                        rsp_valid;
   logic signed [OPERAND_W-1:0] rsp_scaled_result;
   logic signed [SCALE_W-1:0]   rsp_decimal_exponent;
   logic [1:0]                  rsp_status;
   int                          errors;
   int                          outstanding;
   int                          cycles = 0;

   signed_decimal_long_divider dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_dividend         (req_dividend),
      .req_divisor          (req_divisor),
      .req_scale_in         (req_scale_in),
      .rsp_valid            (rsp_valid),
      .rsp_scaled_result    (rsp_scaled_result),
      .rsp_decimal_exponent (rsp_decimal_exponent),
      .rsp_status           (rsp_status)
   );

   quotient_monitor quotient_mon (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_dividend         (req_dividend),
      .req_divisor          (req_divisor),
      .req_scale_in         (req_scale_in),
      .rsp_valid            (rsp_valid),
      .rsp_scaled_result    (rsp_scaled_result),
      .rsp_decimal_exponent (rsp_decimal_exponent),
      .rsp_status           (rsp_status),
      .errors               (errors),
      .outstanding          (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= RUN_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Hold one word on the request ports until the divider takes it
   task automatic offer_word(input logic [31:0] num, input logic [31:0] den,
                             input logic [5:0] scale);
      logic taken;
      req_dividend <= num;
      req_divisor  <= den;
      req_scale_in <= scale;
      start        <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         taken = !busy;
         @(negedge clock);
      end
   endtask

   // Drop start for a while and put junk on the idle request fields
   task automatic idle_for(input int gap);
      start        <= 1'b0;
      req_dividend <= $urandom;
      req_divisor  <= $urandom;
      req_scale_in <= 6'($urandom);
      repeat (gap) @(negedge clock);
   endtask

   // Random magnitude of random bit length, random sign
   function automatic logic [31:0] pick_operand(input int max_bits);
      int          bits;
      logic [31:0] v;
      bits = $urandom_range(1, max_bits);
      v = $urandom;
      if (bits < 32) v = v & ((32'd1 << bits) - 32'd1);
      if ($urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   function automatic logic [5:0] pick_scale();
      if ($urandom_range(0, 7) == 0) return 6'($urandom);
      return 6'($urandom_range(0, 32) - 16);
   endfunction

   initial begin : stimulus
      logic [31:0] num, den, quo;
      int          burst;
      reset        = 1'b1;
      start        = 1'b0;
      req_dividend = '0;
      req_divisor  = '0;
      req_scale_in = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words: signs, zero cases, overflow paths, exponent wrap
      offer_word(7, 2, 0);                          idle_for(1);
      offer_word(-7, 2, 1);                         idle_for(2);
      offer_word(7, -2, 2);
      offer_word(-7, -2, -1);                       idle_for(1);
      offer_word(1, 3, 0);
      offer_word(0, -5, 5);                         idle_for(3);
      offer_word(5, 0, 3);
      offer_word(0, 0, 0);                          idle_for(1);
      offer_word(32'h8000_0000, 1, 0);
      offer_word(32'h8000_0000, -1, 0);             idle_for(2);
      offer_word(32'h8000_0000, 32'h8000_0000, 0);
      offer_word(32'h8000_0000, 2, 4);
      offer_word(32'h7fff_ffff, 1, -16);            idle_for(1);
      offer_word(32'h7fff_ffff, -1, 16);
      offer_word(1, 32'h7fff_ffff, 0);
      offer_word(1_000_000_000, 2_000_000_000, 0);  idle_for(5);
      offer_word(32'h7fff_ffff, 2, 0);
      offer_word(1, 8, 31);
      offer_word(-1, 8, -32);                       idle_for(1);
      offer_word(123456, 1000, 0);
      offer_word(-1, 7, -16);
      offer_word(32'h8000_0000, 32'h7fff_ffff, 0);
      offer_word(-3, 32'h8000_0000, 7);             idle_for(2);

      // Random words in bursts with gaps of random length
      for (int n = 0; n < RANDOM_WORDS; n += burst) begin
         burst = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         for (int k = 0; k < burst; k++) begin
            case ($urandom_range(0, 19))
               0: begin
                  num = pick_operand(32);
                  den = 32'd0;
               end
               1, 2, 3, 4: begin
                  // Divisor of the form 2^a * 5^b gives a terminating fraction
                  den = 32'd1 << $urandom_range(0, 6);
                  repeat ($urandom_range(0, 4)) den = den * 32'd5;
                  if ($urandom_range(0, 1) == 1) den = -den;
                  num = pick_operand(28);
               end
               5, 6, 7: begin
                  // Exact quotient
                  den = pick_operand(16);
                  quo = pick_operand(16);
                  num = den * quo;
               end
               8, 9, 10: begin
                  num = 32'($urandom_range(0, 2000)) - 32'd1000;
                  den = 32'($urandom_range(0, 200)) - 32'd100;
               end
               11: begin
                  num = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
                  den = pick_operand(32);
               end
               default: begin
                  num = pick_operand(32);
                  den = pick_operand(32);
               end
            endcase
            offer_word(num, den, pick_scale());
         end
         case ($urandom_range(0, 3))
            0:       idle_for($urandom_range(1, 3));
            1:       idle_for($urandom_range(20, 90));
            default: idle_for($urandom_range(1, 40));
         endcase
      end

      // Drain the pending quotients, then let the divider settle
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
